/* design/tcw_pkg.sv */
package tcw_pkg;

	// Screen geometry defaults
	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	// Depth of the command queue and of the result queue
	localparam int QUEUE_DEPTH = 2;

	// Character codes with a meaning of their own
	localparam logic [7:0] CODE_NEWLINE   = 8'd10;
	localparam logic [7:0] CODE_BACKSPACE = 8'd8;
	localparam logic [7:0] CODE_SPACE     = 8'd32;

	// Configuration register indexes
	localparam logic [1:0] REG_DEFAULT_ATTR = 2'd0;
	localparam logic [1:0] REG_BLANK_ATTR   = 2'd1;
	localparam logic [1:0] REG_CLEAR_ATTR   = 2'd2;

	// Configuration reset values
	localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd7;
	localparam logic [7:0] BLANK_ATTR_RESET   = 8'd7;
	localparam logic [7:0] CLEAR_ATTR_RESET   = 8'd15;

	typedef enum logic [1:0] {
		CMD_COLOR_PUT,
		CMD_DEFAULT_PUT,
		CMD_CLEAR,
		CMD_READ
	} cmd_t;

	// Input transaction
	typedef struct packed {
		cmd_t        command;
		logic [7:0]  character;
		logic [3:0]  foreground;
		logic [3:0]  background;
		logic [10:0] cell_address;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		logic [10:0] cursor_position;
		logic [15:0] cell_data;
		logic        scrolled;
	} result_t;

	// One screen cell: attribute over code
	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] code;
	} cell_t;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  attr;
		logic [7:0]  code;
		logic [10:0] addr;
	} op_t;

	// Attributes the back end needs for blank cells
	typedef struct packed {
		logic [7:0] blank;
		logic [7:0] clear;
	} attr_cfg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_FILL,
		ST_READ
	} back_state_t;

endpackage

/* design/tcw_fifo.sv */
module tcw_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = tcw_pkg::QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	input  logic  pop,
	output item_t rd_item,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

	item_t            slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_DEPTH);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = slots_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/tcw_front.sv */
module tcw_front (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               push,
	input  tcw_pkg::in_item_t  item,
	output logic               full,
	// configuration
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	// toward the command queue and back end
	input  logic               queue_full,
	input  logic               init_busy,
	output logic               op_push,
	output tcw_pkg::op_t       op,
	output tcw_pkg::attr_cfg_t attrs
);

	logic [7:0] default_attr_q;
	logic [7:0] blank_attr_q;
	logic [7:0] clear_attr_q;

	// Attribute registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= tcw_pkg::DEFAULT_ATTR_RESET;
			blank_attr_q   <= tcw_pkg::BLANK_ATTR_RESET;
			clear_attr_q   <= tcw_pkg::CLEAR_ATTR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tcw_pkg::REG_DEFAULT_ATTR: default_attr_q <= cfg_data;
				tcw_pkg::REG_BLANK_ATTR:   blank_attr_q   <= cfg_data;
				tcw_pkg::REG_CLEAR_ATTR:   clear_attr_q   <= cfg_data;
				default:                   ;
			endcase
		end
	end

	assign attrs.blank = blank_attr_q;
	assign attrs.clear = clear_attr_q;

	// Accept while the queue has room and the screen sweep after reset is done
	assign full    = queue_full || init_busy;
	assign op_push = push && !full;

	// Classify the command
	always_comb begin
		op.code = item.character;
		op.addr = item.cell_address;
		op.attr = default_attr_q;
		op.kind = tcw_pkg::OP_PUT;
		unique case (item.command)
			tcw_pkg::CMD_COLOR_PUT: begin
				op.attr = {item.background, item.foreground};
				op.kind = (item.character == tcw_pkg::CODE_NEWLINE) ?
					tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
			end
			tcw_pkg::CMD_DEFAULT_PUT: begin
				if (item.character == tcw_pkg::CODE_BACKSPACE) begin
					op.kind = tcw_pkg::OP_BACKSPACE;
				end else if (item.character == tcw_pkg::CODE_NEWLINE) begin
					op.kind = tcw_pkg::OP_NEWLINE;
				end else begin
					op.kind = tcw_pkg::OP_PUT;
				end
			end
			tcw_pkg::CMD_CLEAR: op.kind = tcw_pkg::OP_CLEAR;
			tcw_pkg::CMD_READ:  op.kind = tcw_pkg::OP_READ;
			default:            op.kind = tcw_pkg::OP_PUT;
		endcase
	end

endmodule

/* design/tcw_back.sv */
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::op_t       op,
	input  logic               op_valid,
	output logic               op_pop,
	input  tcw_pkg::attr_cfg_t attrs,
	input  logic               res_full,
	output logic               res_push,
	output tcw_pkg::result_t   res,
	output logic               init_busy
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ROW_W      = $clog2(ROWS);

	localparam logic [CELL_W-1:0] CELL_LAST  = CELL_W'(CELL_COUNT - 1);
	localparam logic [CELL_W-1:0] ROW_STRIDE = CELL_W'(COLUMNS);
	localparam logic [CELL_W-1:0] LAST_ROW_START = CELL_W'(CELL_COUNT - COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

	tcw_pkg::back_state_t state_q, state_d;

	// Screen memory
	tcw_pkg::cell_t mem [CELL_COUNT];
	tcw_pkg::cell_t rd_data_q;
	logic [CELL_W-1:0] rd_addr;
	logic              mem_we;
	logic [CELL_W-1:0] mem_wa;
	tcw_pkg::cell_t    mem_wd;

	// Cursor kept as linear index plus row and column
	logic [CELL_W-1:0] cur_q, cur_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;

	// Sweep index and one-stage copy pipeline of a scroll
	logic [CELL_W-1:0] sidx_q, sidx_d;
	logic              copy_v_s1, copy_v_d;
	logic [CELL_W-1:0] copy_wa_s1, copy_wa_d;
	logic              rd_hit_q, rd_hit_d;

	logic start;
	logic col_wrap;
	logic row_last;
	logic sweep_last;

	assign start      = (state_q == tcw_pkg::ST_IDLE) && op_valid && !res_full;
	assign col_wrap   = (col_q == COL_LAST);
	assign row_last   = (row_q == ROW_LAST);
	assign sweep_last = (sidx_q == CELL_LAST);
	assign init_busy  = (state_q == tcw_pkg::ST_INIT);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (sweep_last) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (start) begin
					unique case (op.kind)
						tcw_pkg::OP_PUT: begin
							if (col_wrap && row_last) state_d = tcw_pkg::ST_SCROLL;
						end
						tcw_pkg::OP_NEWLINE: begin
							if (row_last) state_d = tcw_pkg::ST_SCROLL;
						end
						tcw_pkg::OP_CLEAR:     state_d = tcw_pkg::ST_FILL;
						tcw_pkg::OP_READ:      state_d = tcw_pkg::ST_READ;
						default:               state_d = tcw_pkg::ST_IDLE;
					endcase
				end
			end
			tcw_pkg::ST_SCROLL: begin
				if (sweep_last) state_d = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				if (!copy_v_s1 && sweep_last) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_FILL: begin
				if (sweep_last) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_READ: state_d = tcw_pkg::ST_IDLE;
			default:          state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// Outputs, memory port and datapath updates
	always_comb begin
		mem_we    = 1'b0;
		mem_wa    = sidx_q;
		mem_wd    = '0;
		rd_addr   = sidx_q;
		op_pop    = 1'b0;
		res_push  = 1'b0;
		res.cursor_position = 11'(cur_q);
		res.cell_data       = '0;
		res.scrolled        = 1'b0;
		cur_d     = cur_q;
		col_d     = col_q;
		row_d     = row_q;
		sidx_d    = sidx_q;
		copy_v_d  = 1'b0;
		copy_wa_d = sidx_q - ROW_STRIDE;
		rd_hit_d  = rd_hit_q;

		// pending copy write of a scroll takes the write port first
		if (copy_v_s1) begin
			mem_we = 1'b1;
			mem_wa = copy_wa_s1;
			mem_wd = rd_data_q;
		end

		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = sidx_q;
				mem_wd = '0;
				sidx_d = sweep_last ? '0 : sidx_q + 1'b1;
			end
			tcw_pkg::ST_IDLE: begin
				rd_addr  = CELL_W'(op.addr);
				op_pop   = start;
				rd_hit_d = (32'(op.addr) < CELL_COUNT);
				if (start) begin
					unique case (op.kind)
						tcw_pkg::OP_PUT: begin
							mem_we = 1'b1;
							mem_wa = cur_q;
							mem_wd = '{attr: op.attr, code: op.code};
							if (col_wrap && row_last) begin
								sidx_d = ROW_STRIDE;
							end else begin
								cur_d = cur_q + 1'b1;
								col_d = col_wrap ? '0 : col_q + 1'b1;
								row_d = col_wrap ? row_q + 1'b1 : row_q;
								res_push = 1'b1;
								res.cursor_position = 11'(cur_q + 1'b1);
							end
						end
						tcw_pkg::OP_NEWLINE: begin
							if (row_last) begin
								sidx_d = ROW_STRIDE;
							end else begin
								cur_d = cur_q - CELL_W'(col_q) + ROW_STRIDE;
								col_d = '0;
								row_d = row_q + 1'b1;
								res_push = 1'b1;
								res.cursor_position = 11'(cur_q - CELL_W'(col_q) + ROW_STRIDE);
							end
						end
						tcw_pkg::OP_BACKSPACE: begin
							res_push = 1'b1;
							if (cur_q != '0) begin
								mem_we = 1'b1;
								mem_wa = cur_q - 1'b1;
								mem_wd = '{attr: attrs.blank, code: tcw_pkg::CODE_SPACE};
								cur_d  = cur_q - 1'b1;
								col_d  = (col_q == '0) ? COL_LAST : col_q - 1'b1;
								row_d  = (col_q == '0) ? row_q - 1'b1 : row_q;
								res.cursor_position = 11'(cur_q - 1'b1);
							end
						end
						tcw_pkg::OP_CLEAR: sidx_d = '0;
						default:           ;
					endcase
				end
			end
			tcw_pkg::ST_SCROLL: begin
				// read one row ahead, write it back next cycle
				rd_addr   = sidx_q;
				copy_v_d  = 1'b1;
				copy_wa_d = sidx_q - ROW_STRIDE;
				sidx_d    = sweep_last ? LAST_ROW_START : sidx_q + 1'b1;
			end
			tcw_pkg::ST_BLANK: begin
				if (!copy_v_s1) begin
					mem_we = 1'b1;
					mem_wa = sidx_q;
					mem_wd = '{attr: attrs.blank, code: tcw_pkg::CODE_SPACE};
					sidx_d = sidx_q + 1'b1;
					if (sweep_last) begin
						cur_d    = LAST_ROW_START;
						col_d    = '0;
						row_d    = ROW_LAST;
						res_push = 1'b1;
						res.cursor_position = 11'(LAST_ROW_START);
						res.scrolled        = 1'b1;
					end
				end
			end
			tcw_pkg::ST_FILL: begin
				mem_we = 1'b1;
				mem_wa = sidx_q;
				mem_wd = '{attr: attrs.clear, code: tcw_pkg::CODE_SPACE};
				sidx_d = sidx_q + 1'b1;
				if (sweep_last) begin
					cur_d    = '0;
					col_d    = '0;
					row_d    = '0;
					res_push = 1'b1;
					res.cursor_position = '0;
				end
			end
			tcw_pkg::ST_READ: begin
				res_push      = 1'b1;
				res.cell_data = rd_hit_q ? rd_data_q : '0;
			end
			default: ;
		endcase
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		copy_wa_s1 <= copy_wa_d;
		rd_hit_q   <= rd_hit_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcw_pkg::ST_INIT;
			cur_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			sidx_q    <= '0;
			copy_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			col_q     <= col_d;
			row_q     <= row_d;
			sidx_q    <= sidx_d;
			copy_v_s1 <= copy_v_d;
		end
	end

endmodule

/* design/text_console_writer.sv */
// Channel   Direction  Handshake           Payload
// input     in         push / full         item   (tcw_pkg::in_item_t)
// result    out        pop / empty         result (tcw_pkg::result_t)
// config    in         cfg_write           cfg_index, cfg_data (8 bits)
//
// Puts and newlines that do not scroll, and backspaces, finish straight from idle in the
// back end; a read also passes through the read state. A clear and a scroll sweep the
// screen memory one cell a cycle, set by its single write port.
// After reset the screen memory is zeroed with full held high; configuration writes
// are taken meanwhile.
// Two-entry queues sit between front and back and ahead of the result port.
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tcw_pkg::in_item_t item,
	output logic              full,
	input  logic              pop,
	output tcw_pkg::result_t  result,
	output logic              empty,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	tcw_pkg::op_t       front_op;
	tcw_pkg::op_t       back_op;
	tcw_pkg::attr_cfg_t attrs;
	tcw_pkg::result_t   back_res;
	logic               op_push;
	logic               op_pop;
	logic               op_full;
	logic               op_empty;
	logic               res_push;
	logic               res_full;
	logic               init_busy;

	// Front: accept and classify
	tcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (full),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (op_full),
		.init_busy  (init_busy),
		.op_push    (op_push),
		.op         (front_op),
		.attrs      (attrs)
	);

	// Command queue
	tcw_fifo #(
		.item_t (tcw_pkg::op_t),
		.DEPTH  (tcw_pkg::QUEUE_DEPTH)
	) u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (op_push),
		.wr_item (front_op),
		.pop     (op_pop),
		.rd_item (back_op),
		.full    (op_full),
		.empty   (op_empty)
	);

	// Back: screen memory, cursor and sweeps
	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (back_op),
		.op_valid  (!op_empty),
		.op_pop    (op_pop),
		.attrs     (attrs),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res),
		.init_busy (init_busy)
	);

	// Result queue
	tcw_fifo #(
		.item_t (tcw_pkg::result_t),
		.DEPTH  (tcw_pkg::QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_item (back_res),
		.pop     (pop),
		.rd_item (result),
		.full    (res_full),
		.empty   (empty)
	);

endmodule

/* dv/text_console_writer_tb.sv */
`timescale 1ns / 100ps

module text_console_writer_tb;

	localparam int COLS             = tcw_pkg::COLUMNS_DEFAULT;
	localparam int ROWS             = tcw_pkg::ROWS_DEFAULT;
	localparam int CELLS            = COLS * ROWS;
	// Longest back-end walk (scroll) plus margin
	localparam int SETTLE_CYCLES    = CELLS + 200;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS      = 280;
	localparam longint LIMIT_CYCLES = 12_000_000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              push      = 1'b0;
	tcw_pkg::in_item_t item      = '0;
	logic              full;
	logic              pop       = 1'b0;
	tcw_pkg::result_t  result;
	logic              empty;
	logic              cfg_write = 1'b0;
	logic [1:0]        cfg_index = tcw_pkg::REG_DEFAULT_ATTR;
	logic [7:0]        cfg_data  = '0;

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.pop       (pop),
		.result    (result),
		.empty     (empty),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow console: screen, cursor and attribute registers
	logic [15:0] screen_copy [CELLS] = '{default: '0};
	int unsigned cursor_copy       = 0;
	logic [7:0]  default_attr_copy = tcw_pkg::DEFAULT_ATTR_RESET;
	logic [7:0]  blank_attr_copy   = tcw_pkg::BLANK_ATTR_RESET;
	logic [7:0]  clear_attr_copy   = tcw_pkg::CLEAR_ATTR_RESET;

	// Commands waiting to be sent, and cursor reports still owed by the block
	tcw_pkg::in_item_t command_backlog [$];
	tcw_pkg::result_t  cursor_reports [$];

	int     idle_pct      = 10;
	int     hold_requests = 0;
	int     hold_served   = 0;
	int     hold_left     = 0;
	int     send_gap      = 0;
	int     recv_gap      = 0;
	int     error_count   = 0;
	int     cmds_queued   = 0;
	logic   last_accept   = 1'b0;
	longint cycle_count   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scroll when the cursor ran off the end; returns the scrolled flag
	function automatic logic scroll_if_past_end();
		int i;
		if (cursor_copy < CELLS)
			return 1'b0;
		for (i = 0; i < CELLS - COLS; i++)
			screen_copy[i] = screen_copy[i + COLS];
		for (i = CELLS - COLS; i < CELLS; i++)
			screen_copy[i] = {blank_attr_copy, tcw_pkg::CODE_SPACE};
		cursor_copy = CELLS - COLS;
		return 1'b1;
	endfunction

	function automatic logic write_char(logic [7:0] code, logic [7:0] attr);
		if (code == tcw_pkg::CODE_NEWLINE) begin
			cursor_copy = (cursor_copy / COLS + 1) * COLS;
		end else begin
			screen_copy[cursor_copy] = {attr, code};
			cursor_copy++;
		end
		return scroll_if_past_end();
	endfunction

	// Apply one command to the shadow console and return the cursor report
	function automatic tcw_pkg::result_t run_console_command(tcw_pkg::in_item_t cmd);
		tcw_pkg::result_t report;
		int i;
		report = '0;
		case (cmd.command)
			tcw_pkg::CMD_COLOR_PUT: begin
				report.scrolled = write_char(cmd.character,
					{cmd.background, cmd.foreground});
			end
			tcw_pkg::CMD_DEFAULT_PUT: begin
				if (cmd.character == tcw_pkg::CODE_BACKSPACE) begin
					// backspace at the home position does nothing
					if (cursor_copy > 0) begin
						cursor_copy--;
						screen_copy[cursor_copy] = {blank_attr_copy, tcw_pkg::CODE_SPACE};
					end
				end else begin
					report.scrolled = write_char(cmd.character, default_attr_copy);
				end
			end
			tcw_pkg::CMD_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen_copy[i] = {clear_attr_copy, tcw_pkg::CODE_SPACE};
				cursor_copy = 0;
			end
			tcw_pkg::CMD_READ: begin
				// addresses past the screen read as zero
				if (cmd.cell_address < CELLS)
					report.cell_data = screen_copy[cmd.cell_address];
			end
			default: ;
		endcase
		report.cursor_position = 11'(cursor_copy);
		return report;
	endfunction

	function automatic tcw_pkg::in_item_t console_cmd(tcw_pkg::cmd_t op, logic [7:0] ch,
			logic [3:0] fg, logic [3:0] bg, logic [10:0] addr);
		tcw_pkg::in_item_t c;
		c.command      = op;
		c.character    = ch;
		c.foreground   = fg;
		c.background   = bg;
		c.cell_address = addr;
		return c;
	endfunction

	// Mostly printable text, now and then any byte
	function automatic logic [7:0] text_byte();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	task automatic add_cmd(tcw_pkg::in_item_t c);
		command_backlog.push_back(c);
		cmds_queued++;
	endtask

	// One well-formed burst of console traffic, or a little noise
	task automatic queue_sequence();
		int pick, n, k, r, base;
		logic [7:0] ch;
		logic [10:0] addr;
		tcw_pkg::cmd_t op;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// text run with the odd newline and backspace
			n = $urandom_range(1, 60);
			for (k = 0; k < n; k++) begin
				op = $urandom_range(0, 1) ? tcw_pkg::CMD_DEFAULT_PUT :
					tcw_pkg::CMD_COLOR_PUT;
				r = $urandom_range(0, 99);
				ch = text_byte();
				if (r < 4)
					ch = tcw_pkg::CODE_NEWLINE;
				else if (r < 8)
					ch = tcw_pkg::CODE_BACKSPACE;
				add_cmd(console_cmd(op, ch, 4'($urandom), 4'($urandom), 11'($urandom)));
			end
		end else if (pick < 50) begin
			// newline burst, walks the cursor down and scrolls at the bottom
			n = $urandom_range(1, 16);
			for (k = 0; k < n; k++) begin
				op = $urandom_range(0, 1) ? tcw_pkg::CMD_DEFAULT_PUT :
					tcw_pkg::CMD_COLOR_PUT;
				add_cmd(console_cmd(op, tcw_pkg::CODE_NEWLINE, 4'($urandom), 4'($urandom),
					11'($urandom)));
			end
		end else if (pick < 70) begin
			// reads: anywhere, behind the cursor, or on the bottom row
			n = $urandom_range(1, 8);
			for (k = 0; k < n; k++) begin
				r = $urandom_range(0, 2);
				if (r == 0) begin
					addr = 11'($urandom_range(0, 2047));
				end else if (r == 1) begin
					base = int'(cursor_copy) - int'($urandom_range(0, 40));
					addr = 11'((base < 0) ? 0 : base);
				end else begin
					addr = 11'($urandom_range(CELLS - COLS, CELLS - 1));
				end
				add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'($urandom), 4'($urandom),
					4'($urandom), addr));
			end
		end else if (pick < 82) begin
			n = $urandom_range(1, 12);
			for (k = 0; k < n; k++)
				add_cmd(console_cmd(tcw_pkg::CMD_DEFAULT_PUT, tcw_pkg::CODE_BACKSPACE,
					4'($urandom), 4'($urandom), 11'($urandom)));
		end else if (pick < 85) begin
			add_cmd(console_cmd(tcw_pkg::CMD_CLEAR, 8'($urandom), 4'($urandom),
				4'($urandom), 11'($urandom)));
		end else begin
			// noise: every field random
			n = $urandom_range(1, 4);
			for (k = 0; k < n; k++)
				add_cmd(console_cmd(tcw_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom),
					4'($urandom), 4'($urandom), 11'($urandom)));
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drained();
		while (command_backlog.size() != 0 || cursor_reports.size() != 0)
			@(posedge clk);
	endtask

	// Drain, let the back end finish any walk, reconfigure, then send traffic
	task automatic run_phase(logic [7:0] dflt, logic [7:0] blank, logic [7:0] clr,
			bit long_hold, bit quiet);
		int target;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(tcw_pkg::REG_DEFAULT_ATTR, dflt);
		write_reg(tcw_pkg::REG_BLANK_ATTR, blank);
		write_reg(tcw_pkg::REG_CLEAR_ATTR, clr);
		if (quiet)
			idle_pct = 0;
		if (long_hold)
			hold_requests++;
		add_cmd(console_cmd(tcw_pkg::CMD_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
			11'($urandom)));
		target = cmds_queued + PHASE_ITEMS;
		while (cmds_queued < target) begin
			while (command_backlog.size() >= 4)
				@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			end
			queue_sequence();
		end
	endtask

	// Sender: offers the oldest pending command, idles in bursts between transactions
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !last_accept) begin
			push <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap--;
			push <= 1'b0;
		end else if (command_backlog.size() == 0) begin
			push <= 1'b0;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			send_gap = $urandom_range(0, 12);
			push <= 1'b0;
		end else begin
			push <= 1'b1;
			item <= command_backlog[0];
		end
	end

	// Receiver: long hold when asked, otherwise random stall bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_served < hold_requests) begin
			hold_served++;
			hold_left = LONG_HOLD_CYCLES - 1;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			pop <= 1'b0;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			recv_gap = $urandom_range(0, 12);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Sample config writes and both transaction ports at the rising edge
	always @(posedge clk) begin
		tcw_pkg::result_t want;
		if (arst_n) begin
			last_accept = push && !full;
			if (cfg_write) begin
				case (cfg_index)
					tcw_pkg::REG_DEFAULT_ATTR: default_attr_copy = cfg_data;
					tcw_pkg::REG_BLANK_ATTR:   blank_attr_copy = cfg_data;
					tcw_pkg::REG_CLEAR_ATTR:   clear_attr_copy = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				void'(command_backlog.pop_front());
				cursor_reports.push_back(run_console_command(item));
			end
			if (pop && !empty) begin
				if (cursor_reports.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: unexpected result cursor %0d data %h scrolled %b",
							$realtime, result.cursor_position, result.cell_data,
							result.scrolled);
				end else begin
					want = cursor_reports.pop_front();
					if (result.cursor_position !== want.cursor_position ||
							result.cell_data !== want.cell_data ||
							result.scrolled !== want.scrolled) begin
						error_count++;
						if (error_count <= 10)
							$display(
								"%0t: mismatch exp/got cursor %0d/%0d data %h/%h scrolled %b/%b",
								$realtime,
								want.cursor_position, result.cursor_position,
								want.cell_data, result.cell_data,
								want.scrolled, result.scrolled);
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values written back explicitly; the block takes them during its clearing pass
		write_reg(tcw_pkg::REG_DEFAULT_ATTR, tcw_pkg::DEFAULT_ATTR_RESET);
		write_reg(tcw_pkg::REG_BLANK_ATTR, tcw_pkg::BLANK_ATTR_RESET);
		write_reg(tcw_pkg::REG_CLEAR_ATTR, tcw_pkg::CLEAR_ATTR_RESET);

		// Directed: zeroed screen, reads past the end, field extremes, backspace cases
		add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, 11'd2047));
		add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'(CELLS - 1)));
		add_cmd(console_cmd(tcw_pkg::CMD_COLOR_PUT, 8'h41, 4'hF, 4'hF, 11'd2047));
		add_cmd(console_cmd(tcw_pkg::CMD_COLOR_PUT, tcw_pkg::CODE_BACKSPACE, 4'h0, 4'h0,
			11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_DEFAULT_PUT, 8'hFF, 4'h0, 4'h0, 11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_DEFAULT_PUT, 8'h00, 4'hF, 4'hF, 11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_DEFAULT_PUT, tcw_pkg::CODE_BACKSPACE, 4'h0, 4'h0,
			11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd3));
		add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_DEFAULT_PUT, tcw_pkg::CODE_NEWLINE, 4'h0, 4'h0,
			11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_COLOR_PUT, tcw_pkg::CODE_NEWLINE, 4'h5, 4'hA,
			11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_COLOR_PUT, 8'h7A, 4'h3, 4'hC, 11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'(2 * COLS)));
		add_cmd(console_cmd(tcw_pkg::CMD_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_DEFAULT_PUT, tcw_pkg::CODE_BACKSPACE, 4'h0, 4'h0,
			11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0));
		add_cmd(console_cmd(tcw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'(CELLS - 1)));

		// Random phases over several attribute settings; last one runs without idling
		run_phase(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
		run_phase(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b1);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && cursor_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
design/tcw_pkg.sv
design/tcw_fifo.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_writer.sv
dv/text_console_writer_tb.sv
